// File: rtl/filer_packet_receiver_core_defines.svh
// Assertion helpers for the filer packet receiver checker.
`ifndef FILER_PACKET_RECEIVER_CORE_DEFINES_SVH
`define FILER_PACKET_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define FPR_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("filer packet receiver check failed");

// Next-cycle implication, disabled while reset is held.
`define FPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("filer packet receiver check failed");

`endif

// File: rtl/fpr_pkg.sv
package fpr_pkg;

    // Function codes at or above this limit are invalid.
    localparam int FUNC_CODES = 16;
    localparam logic [7:0] FUNC_LIMIT = 8'(FUNC_CODES);
    localparam logic [7:0] FUNC_TOP = 8'd15;

    localparam int LAYOUT_W = 48;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_LAYOUT = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SOH = 4'd1;

    localparam logic [LAYOUT_W-1:0] LAYOUT_RESET = {LAYOUT_W{1'b1}};
    localparam logic [7:0] SOH_RESET = 8'h01;

    // Input item kinds.
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TIMEOUT = 1'b1;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_OUTCOME = 1'b1;

    // Packet outcomes.
    localparam logic [2:0] OC_OK = 3'd0;
    localparam logic [2:0] OC_DIR_END = 3'd1;
    localparam logic [2:0] OC_BAD_PACKET = 3'd2;
    localparam logic [2:0] OC_BAD_FUNC = 3'd3;
    localparam logic [2:0] OC_BAD_CRC = 3'd4;
    localparam logic [2:0] OC_TIMEOUT = 3'd5;

    // Layout classes.
    localparam logic [2:0] CLS_TWO_ZEROS = 3'd0;
    localparam logic [2:0] CLS_SIZE = 3'd1;
    localparam logic [2:0] CLS_SIX_ZEROS = 3'd2;
    localparam logic [2:0] CLS_DATA = 3'd3;
    localparam logic [2:0] CLS_DIR = 3'd4;
    localparam logic [2:0] CLS_INVALID = 3'd7;

    // Framing bytes.
    localparam logic [7:0] BYTE_SYN = 8'h16;
    localparam logic [7:0] BYTE_DLE = 8'h10;
    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_ETX = 8'h03;
    localparam logic [7:0] BYTE_DIR_MORE = 8'h01;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic       func;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  data_byte;
        logic [2:0]  outcome;
        logic [7:0]  function_code;
        logic [7:0]  packet_count;
        logic [7:0]  packet_status;
        logic [15:0] payload_size;
        logic [15:0] received_crc;
    } out_item_t;

    typedef struct packed {
        logic [LAYOUT_W-1:0] layout_table;
        logic [7:0]          soh_value;
    } cfg_t;

    // Reflected CRC-16 update over one byte.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/fpr_in_reg.sv
module fpr_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fpr_pkg::in_item_t s_item,
    input  logic              take,
    output logic              in_valid,
    output fpr_pkg::in_item_t in_item
);

    logic              valid_reg;
    fpr_pkg::in_item_t item_reg;

    assign s_ready  = !valid_reg || take;
    assign in_valid = valid_reg;
    assign in_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// File: rtl/fpr_cfg.sv
module fpr_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fpr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fpr_pkg::CFG_DATA_W-1:0]     cfg_data,
    output fpr_pkg::cfg_t                      cfg
);

    fpr_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Drop writes to unknown indexes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.layout_table <= fpr_pkg::LAYOUT_RESET;
            cfg_reg.soh_value    <= fpr_pkg::SOH_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                fpr_pkg::CFG_IDX_LAYOUT: cfg_reg.layout_table <= cfg_data;
                fpr_pkg::CFG_IDX_SOH:    cfg_reg.soh_value    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/fpr_parser.sv
module fpr_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  fpr_pkg::cfg_t      cfg,
    input  logic               in_valid,
    input  fpr_pkg::in_item_t  in_item,
    output logic               take,
    output logic               m_valid,
    input  logic               m_ready,
    output fpr_pkg::out_item_t m_item
);

    typedef enum logic [3:0] {
        PH_HUNT, PH_SOH, PH_FUNC, PH_COUNT, PH_STATUS, PH_MARK, PH_PREZ, PH_SZLO,
        PH_SZHI, PH_PAY, PH_DIR0, PH_POSTZ, PH_CRCM, PH_ETX, PH_CRCLO, PH_CRCHI
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [2:0]         sig_reg, sig_next;
    logic [15:0]        crc_reg, crc_next;
    logic               skip_reg, skip_next;
    logic [7:0]         func_reg, func_next;
    logic [7:0]         count_reg, count_next;
    logic [7:0]         status_reg, status_next;
    logic [2:0]         class_reg, class_next;
    logic [15:0]        size_reg, size_next;
    logic [15:0]        left_reg, left_next;
    logic [2:0]         zeros_reg, zeros_next;
    logic               dir_end_reg, dir_end_next;
    logic [7:0]         crc_lo_reg, crc_lo_next;
    logic               out_valid_reg;
    fpr_pkg::out_item_t out_item_reg;

    logic               advance;
    logic               emit;
    fpr_pkg::out_item_t res;
    logic               do_finish;
    logic [2:0]         fin_oc;
    logic [15:0]        fin_crc;
    logic [7:0]         b;
    logic [15:0]        rx_crc;
    logic [15:0]        new_size;
    logic [5:0]         lookup_base;
    logic [2:0]         lookup_class;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        case (idx)
            3'd3:    return fpr_pkg::BYTE_DLE;
            3'd4:    return fpr_pkg::BYTE_STX;
            default: return fpr_pkg::BYTE_SYN;
        endcase
    endfunction

    function automatic phase_t after_payload(input logic [2:0] cls);
        return (cls == fpr_pkg::CLS_DIR) ? PH_DIR0 : PH_CRCM;
    endfunction

    assign advance  = !out_valid_reg || m_ready;
    assign take     = in_valid && advance;
    assign m_valid  = out_valid_reg;
    assign m_item   = out_item_reg;
    assign b        = in_item.byte_value;
    assign rx_crc   = {b, crc_lo_reg};
    assign new_size = {b, size_reg[7:0]};

    always_comb begin
        lookup_base = {2'b00, func_reg[3:0]} * 6'd3;
        if (func_reg >= fpr_pkg::FUNC_LIMIT || func_reg > fpr_pkg::FUNC_TOP) begin
            lookup_class = fpr_pkg::CLS_INVALID;
        end else begin
            lookup_class = cfg.layout_table[lookup_base +: 3];
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        sig_next     = sig_reg;
        crc_next     = crc_reg;
        skip_next    = skip_reg;
        func_next    = func_reg;
        count_next   = count_reg;
        status_next  = status_reg;
        class_next   = class_reg;
        size_next    = size_reg;
        left_next    = left_reg;
        zeros_next   = zeros_reg;
        dir_end_next = dir_end_reg;
        crc_lo_next  = crc_lo_reg;
        emit         = 1'b0;
        do_finish    = 1'b0;
        fin_oc       = fpr_pkg::OC_OK;
        fin_crc      = 16'h0000;
        res          = '0;

        if (in_item.func == fpr_pkg::FUNC_TIMEOUT) begin
            skip_next = 1'b0;
            do_finish = 1'b1;
            fin_oc    = fpr_pkg::OC_TIMEOUT;
        end else if (skip_reg) begin
            // Drop the second byte of a doubled DLE.
            skip_next = 1'b0;
        end else if (phase_reg == PH_HUNT) begin
            if (b == sig_byte(sig_reg)) begin
                if (sig_reg == 3'd4) begin
                    sig_next   = 3'd0;
                    phase_next = PH_SOH;
                end else begin
                    sig_next = sig_reg + 3'd1;
                end
            end else begin
                sig_next = 3'd0;
            end
        end else begin
            if (!(phase_reg inside {PH_CRCM, PH_CRCLO, PH_CRCHI})) begin
                crc_next = fpr_pkg::crc16_byte(crc_reg, b);
                if (b == fpr_pkg::BYTE_DLE) begin
                    skip_next = 1'b1;
                end
            end
            case (phase_reg)
                PH_SOH: begin
                    if (b != cfg.soh_value) begin
                        do_finish = 1'b1;
                        fin_oc    = fpr_pkg::OC_BAD_PACKET;
                    end else begin
                        phase_next = PH_FUNC;
                    end
                end
                PH_FUNC: begin
                    func_next  = b;
                    phase_next = PH_COUNT;
                end
                PH_COUNT: begin
                    count_next = b;
                    phase_next = PH_STATUS;
                end
                PH_STATUS: begin
                    status_next = b;
                    phase_next  = PH_MARK;
                end
                PH_MARK: begin
                    class_next = lookup_class;
                    if (b != fpr_pkg::BYTE_STX) begin
                        do_finish = 1'b1;
                        fin_oc    = fpr_pkg::OC_BAD_PACKET;
                    end else begin
                        case (lookup_class)
                            fpr_pkg::CLS_TWO_ZEROS: begin
                                zeros_next = 3'd2;
                                phase_next = PH_POSTZ;
                            end
                            fpr_pkg::CLS_SIX_ZEROS: begin
                                zeros_next = 3'd6;
                                phase_next = PH_POSTZ;
                            end
                            fpr_pkg::CLS_SIZE, fpr_pkg::CLS_DATA, fpr_pkg::CLS_DIR: begin
                                zeros_next = 3'd4;
                                phase_next = PH_PREZ;
                            end
                            default: begin
                                do_finish = 1'b1;
                                fin_oc    = fpr_pkg::OC_BAD_FUNC;
                            end
                        endcase
                    end
                end
                PH_PREZ: begin
                    if (b != fpr_pkg::BYTE_ZERO) begin
                        do_finish = 1'b1;
                        fin_oc    = fpr_pkg::OC_BAD_PACKET;
                    end else begin
                        zeros_next = zeros_reg - 3'd1;
                        if (zeros_reg == 3'd1) begin
                            phase_next = PH_SZLO;
                        end
                    end
                end
                PH_SZLO: begin
                    size_next  = {8'h00, b};
                    phase_next = PH_SZHI;
                end
                PH_SZHI: begin
                    size_next = new_size;
                    left_next = new_size;
                    if (class_reg == fpr_pkg::CLS_SIZE) begin
                        phase_next = PH_CRCM;
                    end else if (new_size == 16'h0000) begin
                        phase_next = after_payload(class_reg);
                    end else begin
                        phase_next = PH_PAY;
                    end
                end
                PH_PAY: begin
                    emit              = 1'b1;
                    res.result_kind   = fpr_pkg::KIND_PAYLOAD;
                    res.data_byte     = b;
                    res.function_code = func_reg;
                    res.packet_count  = count_reg;
                    res.packet_status = status_reg;
                    res.payload_size  = size_reg;
                    left_next         = left_reg - 16'd1;
                    if (left_reg == 16'd1) begin
                        phase_next = after_payload(class_reg);
                    end
                end
                PH_DIR0: begin
                    if (b != fpr_pkg::BYTE_ZERO && b != fpr_pkg::BYTE_DIR_MORE) begin
                        do_finish = 1'b1;
                        fin_oc    = fpr_pkg::OC_BAD_PACKET;
                    end else begin
                        dir_end_next = (b == fpr_pkg::BYTE_ZERO);
                        zeros_next   = 3'd3;
                        phase_next   = PH_POSTZ;
                    end
                end
                PH_POSTZ: begin
                    if (b != fpr_pkg::BYTE_ZERO) begin
                        do_finish = 1'b1;
                        fin_oc    = fpr_pkg::OC_BAD_PACKET;
                    end else begin
                        zeros_next = zeros_reg - 3'd1;
                        if (zeros_reg == 3'd1) begin
                            phase_next = PH_CRCM;
                        end
                    end
                end
                PH_CRCM: begin
                    if (b != fpr_pkg::BYTE_DLE) begin
                        do_finish = 1'b1;
                        fin_oc    = fpr_pkg::OC_BAD_PACKET;
                    end else begin
                        phase_next = PH_ETX;
                    end
                end
                PH_ETX: begin
                    if (b != fpr_pkg::BYTE_ETX) begin
                        do_finish = 1'b1;
                        fin_oc    = fpr_pkg::OC_BAD_PACKET;
                    end else begin
                        phase_next = PH_CRCLO;
                    end
                end
                PH_CRCLO: begin
                    crc_lo_next = b;
                    phase_next  = PH_CRCHI;
                end
                PH_CRCHI: begin
                    do_finish = 1'b1;
                    fin_crc   = rx_crc;
                    if (rx_crc != crc_reg) begin
                        fin_oc = fpr_pkg::OC_BAD_CRC;
                    end else begin
                        fin_oc = dir_end_reg ? fpr_pkg::OC_DIR_END : fpr_pkg::OC_OK;
                    end
                end
                default: ;
            endcase
        end

        // Report the outcome with the current latches, then clear the packet.
        if (do_finish) begin
            emit              = 1'b1;
            res.result_kind   = fpr_pkg::KIND_OUTCOME;
            res.data_byte     = 8'h00;
            res.outcome       = fin_oc;
            res.function_code = func_reg;
            res.packet_count  = count_reg;
            res.packet_status = status_reg;
            res.payload_size  = size_reg;
            res.received_crc  = fin_crc;
            phase_next        = PH_HUNT;
            sig_next          = 3'd0;
            crc_next          = 16'h0000;
            func_next         = 8'h00;
            count_next        = 8'h00;
            status_next       = 8'h00;
            class_next        = 3'd0;
            size_next         = 16'h0000;
            left_next         = 16'h0000;
            zeros_next        = 3'd0;
            dir_end_next      = 1'b0;
            crc_lo_next       = 8'h00;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            sig_reg       <= 3'd0;
            crc_reg       <= 16'h0000;
            skip_reg      <= 1'b0;
            func_reg      <= 8'h00;
            count_reg     <= 8'h00;
            status_reg    <= 8'h00;
            class_reg     <= 3'd0;
            size_reg      <= 16'h0000;
            left_reg      <= 16'h0000;
            zeros_reg     <= 3'd0;
            dir_end_reg   <= 1'b0;
            crc_lo_reg    <= 8'h00;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                phase_reg   <= phase_next;
                sig_reg     <= sig_next;
                crc_reg     <= crc_next;
                skip_reg    <= skip_next;
                func_reg    <= func_next;
                count_reg   <= count_next;
                status_reg  <= status_next;
                class_reg   <= class_next;
                size_reg    <= size_next;
                left_reg    <= left_next;
                zeros_reg   <= zeros_next;
                dir_end_reg <= dir_end_next;
                crc_lo_reg  <= crc_lo_next;
            end
            if (advance) begin
                out_valid_reg <= take && emit;
            end
        end
        if (take && emit) begin
            out_item_reg <= res;
        end
    end

endmodule

// File: rtl/filer_packet_receiver_core.sv
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      fpr_pkg::in_item_t  (func, byte_value)
// m_        out        m_valid / m_ready      fpr_pkg::out_item_t (result and packet latches)
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data (0 layout_table, 1 soh_value)
//
// One item per cycle sustained while m_ is not stalled; an item taken on s_ reaches m_
// through the input register followed by the parser's result register.
// The byte-wide CRC-16 update and the phase decode sit in the single parser stage.
// aresetn is synchronous and active low; it clears all packet state, the output
// valid and the configuration registers to their defaults.
// A stalled m_ holds its item; s_ keeps taking items while the input register can drain.
// cfg_ready is always high; write only while the block is idle.
module filer_packet_receiver_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  fpr_pkg::in_item_t               s_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output fpr_pkg::out_item_t              m_item,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fpr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fpr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    fpr_pkg::cfg_t     cfg;
    fpr_pkg::in_item_t in_item;
    logic              in_valid;
    logic              take;

    // Register each accepted item ahead of the parser.
    fpr_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .take     (take),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    // Layout table and expected SOH byte.
    fpr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Advance the framing state and register at most one result per item.
    fpr_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_item  (in_item),
        .take     (take),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

// File: rtl/fpr_checker.sv
`include "filer_packet_receiver_core_defines.svh"

module fpr_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input fpr_pkg::out_item_t m_item
);

    `FPR_ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid && $stable(m_item))

    `FPR_ASSERT_IMPLIES(a_payload_clean, m_valid && m_item.result_kind == fpr_pkg::KIND_PAYLOAD, m_item.outcome == fpr_pkg::OC_OK && m_item.received_crc == 16'h0000)

    `FPR_ASSERT_IMPLIES(a_payload_sized, m_valid && m_item.result_kind == fpr_pkg::KIND_PAYLOAD, m_item.payload_size != 16'h0000)

    `FPR_ASSERT_IMPLIES(a_outcome_clean, m_valid && m_item.result_kind == fpr_pkg::KIND_OUTCOME, m_item.data_byte == 8'h00 && m_item.outcome <= fpr_pkg::OC_TIMEOUT)

endmodule

bind filer_packet_receiver_core fpr_checker u_fpr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

// File: test/filer_packet_receiver_core_tb.sv
`timescale 1ns / 1ps

module filer_packet_receiver_core_tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PRINT_MAX = 200;
    localparam logic [7:0] SIGNATURE [5] = '{fpr_pkg::BYTE_SYN, fpr_pkg::BYTE_SYN,
                                             fpr_pkg::BYTE_SYN, fpr_pkg::BYTE_DLE,
                                             fpr_pkg::BYTE_STX};

    typedef enum logic [4:0] {
        ST_HUNT, ST_SOH, ST_FUNC, ST_COUNT, ST_STATUS, ST_MARK, ST_PRE_ZEROS,
        ST_SIZE_LO, ST_SIZE_HI, ST_PAYLOAD, ST_DIR_MARK, ST_POST_ZEROS,
        ST_CRC_DLE, ST_ETX, ST_CRC_LO, ST_CRC_HI
    } rx_phase_t;

    // Layout class of function code c in the table.
    function automatic logic [2:0] class_at(logic [fpr_pkg::LAYOUT_W-1:0] lay, int c);
        logic [5:0] base;
        base = 6'(3 * c);
        return lay[base +: 3];
    endfunction

    // Tracks the receiver's framing state and holds the results it must emit, in order.
    class frame_tracker_t;
        logic [fpr_pkg::LAYOUT_W-1:0] layout;
        logic [7:0]                   soh;
        rx_phase_t                    phase;
        int                           sig_hits;
        logic [15:0]                  crc_acc;
        bit                           drop_next;
        logic [7:0]                   func_l, count_l, status_l, crc_lo;
        logic [2:0]                   cls;
        logic [15:0]                  size_l, left;
        int                           zeros_left;
        bit                           dir_end;
        fpr_pkg::out_item_t           awaited[$];
        int                           failures;
        int                           payload_seen;
        int                           outcome_seen[8];

        function new();
            layout = fpr_pkg::LAYOUT_RESET;
            soh = fpr_pkg::SOH_RESET;
            drop_next = 1'b0;
            failures = 0;
            payload_seen = 0;
            foreach (outcome_seen[i]) outcome_seen[i] = 0;
            clear_frame();
        endfunction

        // Reflected CRC-16, one bit at a time, LSB first.
        static function logic [15:0] crc_step(logic [15:0] acc, logic [7:0] b);
            logic [15:0] c;
            logic        fb;
            c = acc;
            for (int i = 0; i < 8; i++) begin
                fb = c[0] ^ b[i];
                c = c >> 1;
                if (fb) c = c ^ fpr_pkg::CRC_POLY;
            end
            return c;
        endfunction

        function void set_register(logic [fpr_pkg::CFG_INDEX_W-1:0] idx,
                                   logic [fpr_pkg::CFG_DATA_W-1:0] data);
            if (idx == fpr_pkg::CFG_IDX_LAYOUT) layout = data[fpr_pkg::LAYOUT_W-1:0];
            else if (idx == fpr_pkg::CFG_IDX_SOH) soh = data[7:0];
        endfunction

        function void clear_frame();
            phase = ST_HUNT;
            sig_hits = 0;
            crc_acc = '0;
            func_l = '0;
            count_l = '0;
            status_l = '0;
            cls = '0;
            size_l = '0;
            left = '0;
            zeros_left = 0;
            dir_end = 1'b0;
            crc_lo = '0;
        endfunction

        function void post_result(logic kind, logic [7:0] data, logic [2:0] oc,
                                  logic [15:0] rx_crc);
            fpr_pkg::out_item_t e;
            e.result_kind = kind;
            e.data_byte = data;
            e.outcome = oc;
            e.function_code = func_l;
            e.packet_count = count_l;
            e.packet_status = status_l;
            e.payload_size = size_l;
            e.received_crc = rx_crc;
            awaited.push_back(e);
        endfunction

        function void close_frame(logic [2:0] oc, logic [15:0] rx_crc);
            post_result(fpr_pkg::KIND_OUTCOME, 8'h00, oc, rx_crc);
            clear_frame();
        endfunction

        // Advance the framing state by one accepted item.
        function void take_item(fpr_pkg::in_item_t it);
            logic [7:0]  b;
            logic [15:0] rx;
            b = it.byte_value;
            if (it.func == fpr_pkg::FUNC_TIMEOUT) begin
                drop_next = 1'b0;
                close_frame(fpr_pkg::OC_TIMEOUT, 16'h0000);
                return;
            end
            if (drop_next) begin
                drop_next = 1'b0;
                return;
            end
            if (phase == ST_HUNT) begin
                // A mismatching byte restarts the hunt and is not tried as a first byte.
                if (sig_hits < 5 && b == SIGNATURE[sig_hits]) sig_hits++;
                else sig_hits = 0;
                if (sig_hits >= 5) begin
                    clear_frame();
                    phase = ST_SOH;
                end
                return;
            end
            if (!(phase inside {ST_CRC_DLE, ST_CRC_LO, ST_CRC_HI})) begin
                crc_acc = crc_step(crc_acc, b);
                if (b == fpr_pkg::BYTE_DLE) drop_next = 1'b1;
            end
            case (phase)
                ST_SOH: begin
                    if (b != soh) close_frame(fpr_pkg::OC_BAD_PACKET, 16'h0000);
                    else phase = ST_FUNC;
                end
                ST_FUNC: begin
                    func_l = b;
                    phase = ST_COUNT;
                end
                ST_COUNT: begin
                    count_l = b;
                    phase = ST_STATUS;
                end
                ST_STATUS: begin
                    status_l = b;
                    phase = ST_MARK;
                end
                ST_MARK: begin
                    if (b != fpr_pkg::BYTE_STX) begin
                        close_frame(fpr_pkg::OC_BAD_PACKET, 16'h0000);
                    end else begin
                        if (func_l >= fpr_pkg::FUNC_LIMIT || func_l > fpr_pkg::FUNC_TOP)
                            cls = fpr_pkg::CLS_INVALID;
                        else
                            cls = class_at(layout, int'(func_l));
                        case (cls)
                            fpr_pkg::CLS_TWO_ZEROS: begin
                                zeros_left = 2;
                                phase = ST_POST_ZEROS;
                            end
                            fpr_pkg::CLS_SIX_ZEROS: begin
                                zeros_left = 6;
                                phase = ST_POST_ZEROS;
                            end
                            fpr_pkg::CLS_SIZE, fpr_pkg::CLS_DATA, fpr_pkg::CLS_DIR: begin
                                zeros_left = 4;
                                phase = ST_PRE_ZEROS;
                            end
                            default: close_frame(fpr_pkg::OC_BAD_FUNC, 16'h0000);
                        endcase
                    end
                end
                ST_PRE_ZEROS: begin
                    if (b != fpr_pkg::BYTE_ZERO) begin
                        close_frame(fpr_pkg::OC_BAD_PACKET, 16'h0000);
                    end else begin
                        zeros_left--;
                        if (zeros_left == 0) phase = ST_SIZE_LO;
                    end
                end
                ST_SIZE_LO: begin
                    size_l = {8'h00, b};
                    phase = ST_SIZE_HI;
                end
                ST_SIZE_HI: begin
                    size_l[15:8] = b;
                    left = size_l;
                    if (cls == fpr_pkg::CLS_SIZE) phase = ST_CRC_DLE;
                    else if (left == 0)
                        phase = (cls == fpr_pkg::CLS_DIR) ? ST_DIR_MARK : ST_CRC_DLE;
                    else phase = ST_PAYLOAD;
                end
                ST_PAYLOAD: begin
                    post_result(fpr_pkg::KIND_PAYLOAD, b, fpr_pkg::OC_OK, 16'h0000);
                    left--;
                    if (left == 0)
                        phase = (cls == fpr_pkg::CLS_DIR) ? ST_DIR_MARK : ST_CRC_DLE;
                end
                ST_DIR_MARK: begin
                    if (b != fpr_pkg::BYTE_ZERO && b != fpr_pkg::BYTE_DIR_MORE) begin
                        close_frame(fpr_pkg::OC_BAD_PACKET, 16'h0000);
                    end else begin
                        dir_end = (b == fpr_pkg::BYTE_ZERO);
                        zeros_left = 3;
                        phase = ST_POST_ZEROS;
                    end
                end
                ST_POST_ZEROS: begin
                    if (b != fpr_pkg::BYTE_ZERO) begin
                        close_frame(fpr_pkg::OC_BAD_PACKET, 16'h0000);
                    end else begin
                        zeros_left--;
                        if (zeros_left == 0) phase = ST_CRC_DLE;
                    end
                end
                ST_CRC_DLE: begin
                    if (b != fpr_pkg::BYTE_DLE) close_frame(fpr_pkg::OC_BAD_PACKET, 16'h0000);
                    else phase = ST_ETX;
                end
                ST_ETX: begin
                    if (b != fpr_pkg::BYTE_ETX) close_frame(fpr_pkg::OC_BAD_PACKET, 16'h0000);
                    else phase = ST_CRC_LO;
                end
                ST_CRC_LO: begin
                    crc_lo = b;
                    phase = ST_CRC_HI;
                end
                ST_CRC_HI: begin
                    rx = {b, crc_lo};
                    if (rx != crc_acc) close_frame(fpr_pkg::OC_BAD_CRC, rx);
                    else close_frame(dir_end ? fpr_pkg::OC_DIR_END : fpr_pkg::OC_OK, rx);
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                failures++;
                if (failures <= PRINT_MAX)
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, field, want, got);
            end
        endfunction

        function void match_result(fpr_pkg::out_item_t got);
            fpr_pkg::out_item_t want;
            if (got.result_kind == fpr_pkg::KIND_PAYLOAD) payload_seen++;
            else outcome_seen[got.outcome]++;
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= PRINT_MAX)
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = awaited.pop_front();
            compare_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
            compare_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
            compare_field("outcome", 16'(want.outcome), 16'(got.outcome));
            compare_field("function_code", 16'(want.function_code), 16'(got.function_code));
            compare_field("packet_count", 16'(want.packet_count), 16'(got.packet_count));
            compare_field("packet_status", 16'(want.packet_status), 16'(got.packet_status));
            compare_field("payload_size", want.payload_size, got.payload_size);
            compare_field("received_crc", want.received_crc, got.received_crc);
        endfunction
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    fpr_pkg::in_item_t               s_item;
    logic                            m_valid;
    logic                            m_ready = 1'b1;
    fpr_pkg::out_item_t              m_item;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [fpr_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [fpr_pkg::CFG_DATA_W-1:0]  cfg_data;

    frame_tracker_t               tracker;
    fpr_pkg::in_item_t            stim[$];
    logic [15:0]                  frame_crc;
    logic [fpr_pkg::LAYOUT_W-1:0] cur_layout;
    logic [7:0]                   cur_soh;
    int                           items_sent;
    int                           timeouts_sent;
    int                           frames_built;
    int                           settings_used;
    int                           cycle_count = 0;
    int                           in_stretch = 0;
    bit                           in_calm = 1'b0;
    int                           out_stretch = 0;
    bit                           out_calm = 1'b0;
    int                           hold_cycles = 0;

    filer_packet_receiver_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Draw a random wait; runs of calm items keep the side busy back to back.
    function automatic int draw_wait(inout int stretch_left, inout bit calm);
        if (stretch_left == 0) begin
            stretch_left = $urandom_range(8, 64);
            calm = ($urandom_range(0, 2) == 0);
        end
        stretch_left--;
        if (calm) return 0;
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic void push_raw(logic [7:0] v);
        fpr_pkg::in_item_t t;
        t.func = fpr_pkg::FUNC_BYTE;
        t.byte_value = v;
        stim.push_back(t);
    endfunction

    function automatic void push_timeout();
        fpr_pkg::in_item_t t;
        t.func = fpr_pkg::FUNC_TIMEOUT;
        t.byte_value = 8'($urandom_range(0, 255));
        stim.push_back(t);
    endfunction

    // Add a CRC-counted byte; a 10 is doubled, now and then with a junk second copy.
    function automatic void push_counted(logic [7:0] v);
        push_raw(v);
        frame_crc = frame_tracker_t::crc_step(frame_crc, v);
        if (v == fpr_pkg::BYTE_DLE)
            push_raw(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                 : fpr_pkg::BYTE_DLE);
    endfunction

    function automatic void push_signature(int broken_at);
        for (int i = 0; i < 5; i++)
            push_raw((i == broken_at) ? 8'($urandom_range(0, 255)) : SIGNATURE[i]);
    endfunction

    function automatic logic [7:0] payload_byte();
        return ($urandom_range(0, 7) == 0) ? fpr_pkg::BYTE_DLE : 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [fpr_pkg::LAYOUT_W-1:0] random_layout(int bad_odds);
        logic [fpr_pkg::LAYOUT_W-1:0] t;
        logic [5:0]                   base;
        for (int c = 0; c < 16; c++) begin
            base = 6'(3 * c);
            t[base +: 3] = ($urandom_range(0, 9) < bad_odds) ? 3'($urandom_range(5, 7))
                                                             : 3'($urandom_range(0, 4));
        end
        return t;
    endfunction

    // Queue one frame: mostly well formed for the current layout, sometimes damaged.
    task automatic build_frame();
        int                codes[$];
        int                start;
        int                i;
        logic [7:0]        code;
        logic [2:0]        kind;
        logic [15:0]       frame_size;
        logic [15:0]       crc_tx;
        fpr_pkg::in_item_t tmp;
        frames_built++;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) push_raw(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 29) == 0) push_timeout();
        push_signature(($urandom_range(0, 24) == 0) ? $urandom_range(0, 4) : 5);
        start = stim.size();
        frame_crc = 16'h0000;
        push_counted(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : cur_soh);
        for (int c = 0; c < 16; c++)
            if (class_at(cur_layout, c) <= fpr_pkg::CLS_DIR) codes.push_back(c);
        if (codes.size() > 0 && $urandom_range(0, 6) != 0)
            code = 8'(codes[$urandom_range(0, codes.size() - 1)]);
        else
            code = 8'($urandom_range(0, 255));
        push_counted(code);
        push_counted(8'($urandom_range(0, 255)));
        push_counted(8'($urandom_range(0, 255)));
        push_counted(($urandom_range(0, 24) == 0) ? 8'($urandom_range(0, 255))
                                                  : fpr_pkg::BYTE_STX);
        kind = (code <= fpr_pkg::FUNC_TOP && code < fpr_pkg::FUNC_LIMIT)
               ? class_at(cur_layout, int'(code)) : fpr_pkg::CLS_INVALID;
        case (kind)
            fpr_pkg::CLS_TWO_ZEROS: repeat (2) push_counted(fpr_pkg::BYTE_ZERO);
            fpr_pkg::CLS_SIX_ZEROS: repeat (6) push_counted(fpr_pkg::BYTE_ZERO);
            fpr_pkg::CLS_SIZE, fpr_pkg::CLS_DATA, fpr_pkg::CLS_DIR: begin
                repeat (4) push_counted(fpr_pkg::BYTE_ZERO);
                if (kind == fpr_pkg::CLS_SIZE) begin
                    case ($urandom_range(0, 3))
                        0: frame_size = 16'h0000;
                        1: frame_size = 16'hFFFF;
                        default: frame_size = 16'($urandom_range(0, 65535));
                    endcase
                end else if ($urandom_range(0, 29) == 0) begin
                    frame_size = 16'($urandom_range(256, 65535));
                end else if ($urandom_range(0, 9) == 0) begin
                    frame_size = 16'($urandom_range(9, 48));
                end else begin
                    frame_size = 16'($urandom_range(0, 8));
                end
                push_counted(frame_size[7:0]);
                push_counted(frame_size[15:8]);
                if (kind != fpr_pkg::CLS_SIZE) begin
                    // Cut a huge payload short with a timeout.
                    if (frame_size > 64) begin
                        repeat ($urandom_range(1, 20)) push_counted(payload_byte());
                        push_timeout();
                        return;
                    end
                    repeat (frame_size) push_counted(payload_byte());
                    if (kind == fpr_pkg::CLS_DIR) begin
                        push_counted(($urandom_range(0, 1) == 0) ? fpr_pkg::BYTE_ZERO
                                                                 : fpr_pkg::BYTE_DIR_MORE);
                        repeat (3) push_counted(fpr_pkg::BYTE_ZERO);
                    end
                end
            end
            default: ;
        endcase
        push_raw(fpr_pkg::BYTE_DLE);
        push_counted(fpr_pkg::BYTE_ETX);
        crc_tx = frame_crc;
        if ($urandom_range(0, 9) == 0) crc_tx = crc_tx ^ 16'($urandom_range(1, 65535));
        push_raw(crc_tx[7:0]);
        push_raw(crc_tx[15:8]);
        // Damage one byte, or drop the tail and end with a timeout.
        if ($urandom_range(0, 7) == 0) begin
            i = $urandom_range(start, stim.size() - 1);
            tmp = stim[i];
            tmp.byte_value = ($urandom_range(0, 3) == 0) ? fpr_pkg::BYTE_DLE
                                                         : 8'($urandom_range(0, 255));
            stim[i] = tmp;
        end else if ($urandom_range(0, 11) == 0) begin
            i = $urandom_range(start, stim.size() - 1);
            while (stim.size() > i) void'(stim.pop_back());
            push_timeout();
        end
    endtask

    // Present one item and hold it until the block takes it.
    task automatic send_item(fpr_pkg::in_item_t it);
        int gap;
        gap = draw_wait(in_stretch, in_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (it.func == fpr_pkg::FUNC_TIMEOUT) timeouts_sent++;
        tracker.take_item(it);
    endtask

    task automatic send_stim();
        while (stim.size() > 0) send_item(stim.pop_front());
    endtask

    // Drop valid, wait for every awaited result, then let the pipeline empty.
    task automatic settle();
        s_valid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [fpr_pkg::CFG_INDEX_W-1:0] idx,
                             logic [fpr_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.set_register(idx, data);
        if (idx == fpr_pkg::CFG_IDX_LAYOUT) cur_layout = data[fpr_pkg::LAYOUT_W-1:0];
        else cur_soh = data[7:0];
        @(posedge aclk);
    endtask

    // Result side: check each accepted item, then stall for a drawn number of cycles.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.match_result(m_item);
            hold_cycles = draw_wait(out_stretch, out_calm);
            m_ready <= (hold_cycles == 0);
        end else if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            if (hold_cycles == 0) m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped at cycle %0d with %0d results outstanding",
                     cycle_count, tracker.awaited.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [fpr_pkg::LAYOUT_W-1:0] lay;
        logic [7:0]                   soh_v;
        int                           budget;
        tracker = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cur_layout = fpr_pkg::LAYOUT_RESET;
        cur_soh = fpr_pkg::SOH_RESET;
        items_sent = 0;
        timeouts_sent = 0;
        frames_built = 0;
        settings_used = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening under the reset settings.
        push_timeout();                     // timeout while hunting
        push_raw(fpr_pkg::BYTE_SYN);        // signature broken after one byte
        push_raw(fpr_pkg::BYTE_DLE);
        push_signature(5);                  // bad start byte that is a 10: next byte dropped
        push_raw(fpr_pkg::BYTE_DLE);
        push_raw(8'hAB);
        push_signature(5);                  // function above the table
        push_raw(fpr_pkg::SOH_RESET);
        push_raw(8'hFF);
        push_raw(8'h00);
        push_raw(8'hFF);
        push_raw(fpr_pkg::BYTE_STX);
        push_signature(5);                  // timeout while a doubled 10 is pending
        push_raw(fpr_pkg::SOH_RESET);
        push_raw(fpr_pkg::BYTE_DLE);
        push_timeout();
        send_stim();
        settle();

        // Random frames under a series of register settings, extremes among them.
        for (int p = 0; p < 7; p++) begin
            if (p > 0) begin
                case (p)
                    1: begin lay = random_layout(1); soh_v = fpr_pkg::SOH_RESET; end
                    2: begin lay = '0; soh_v = 8'h00; end
                    3: begin lay = random_layout(4); soh_v = 8'hFF; end
                    4: begin lay = random_layout(1); soh_v = fpr_pkg::BYTE_DLE; end
                    5: begin lay = random_layout(0); soh_v = 8'($urandom_range(0, 255)); end
                    default: begin lay = fpr_pkg::LAYOUT_RESET; soh_v = fpr_pkg::SOH_RESET; end
                endcase
                write_reg(fpr_pkg::CFG_IDX_LAYOUT, fpr_pkg::CFG_DATA_W'(lay));
                write_reg(fpr_pkg::CFG_IDX_SOH, fpr_pkg::CFG_DATA_W'(soh_v));
            end
            settings_used++;
            budget = items_sent + ((p == 0 || p == 6) ? 100 : 220);
            while (items_sent < budget) begin
                build_frame();
                send_stim();
            end
            settle();
        end

        $display("Sent %0d items (%0d timeouts) in %0d frames over %0d register settings",
                 items_sent, timeouts_sent, frames_built, settings_used);
        $display("Checked %0d payload bytes; ok %0d, dir end %0d, bad packet %0d, %s %0d, %s %0d, %s %0d",
                 tracker.payload_seen, tracker.outcome_seen[fpr_pkg::OC_OK],
                 tracker.outcome_seen[fpr_pkg::OC_DIR_END],
                 tracker.outcome_seen[fpr_pkg::OC_BAD_PACKET],
                 "bad function", tracker.outcome_seen[fpr_pkg::OC_BAD_FUNC],
                 "bad crc", tracker.outcome_seen[fpr_pkg::OC_BAD_CRC],
                 "timeout", tracker.outcome_seen[fpr_pkg::OC_TIMEOUT]);
        if (tracker.failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
